/* rtl/postfix_stack_evaluator_core_assert.svh */
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core_assert.svh
// Assertion macros for the postfix stack evaluator. Each macro expects clk
// and rst in scope.
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_CORE_ASSERT_SVH
`define POSTFIX_STACK_EVALUATOR_CORE_ASSERT_SVH

// Condition implies consequence in the same cycle
`define PSE_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle
`define PSE_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pse_pkg.sv */
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, codes and helpers for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int Q_W             = 32;
  // Quotient bits produced by the divider: 32 magnitude bits plus 16 fraction
  localparam int DIV_STEPS       = 48;

  typedef enum logic [2:0] {
    KIND_PUSH  = 3'd0,
    KIND_ADD   = 3'd1,
    KIND_SUB   = 3'd2,
    KIND_MUL   = 3'd3,
    KIND_DIV   = 3'd4,
    KIND_NEG   = 3'd5,
    KIND_FIN   = 3'd6,
    KIND_BADOP = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_DIVZERO   = 3'd2,
    ST_INVALID   = 3'd3,
    ST_OVERFLOW  = 3'd4,
    ST_BADOP     = 3'd5
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic addsub_wr;
    logic mul_prod;
    logic mul_wr;
    logic div_start;
    logic div_wr;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic go_bin;
    logic is_mul;
    logic is_div;
    logic div_done;
  } sts_t;

  // Saturate a 33-bit signed value to Q16.16
  function automatic logic [Q_W-1:0] sat33(input logic [Q_W:0] v);
    logic [Q_W-1:0] r;
    if (v[Q_W] != v[Q_W-1]) begin
      r = v[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  // Saturate a 48-bit signed value to Q16.16
  function automatic logic [Q_W-1:0] sat48(input logic [47:0] v);
    logic [Q_W-1:0] r;
    if ((&v[47:Q_W-1]) || !(|v[47:Q_W-1])) begin
      r = v[Q_W-1:0];
    end else begin
      r = v[47] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* rtl/pse_tok_if.sv */
// ----------------------------------------------------------------------------
// pse_tok_if
// Token channel: one word is a token kind and its operand.
// ----------------------------------------------------------------------------
interface pse_tok_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic signed [31:0] operand;

  modport source (output valid, output kind, output operand, input ready);
  modport sink   (input valid, input kind, input operand, output ready);
endinterface

/* rtl/pse_res_if.sv */
// ----------------------------------------------------------------------------
// pse_res_if
// Result channel: one word is a status, a top value and a finish flag.
// ----------------------------------------------------------------------------
interface pse_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic signed [31:0] top_value;
  logic        final_res;

  modport source (output valid, output status, output top_value, output final_res,
                  input ready);
  modport sink   (input valid, input status, input top_value, input final_res,
                  output ready);
endinterface

/* rtl/pse_div.sv */
// ----------------------------------------------------------------------------
// pse_div
// Iterative Q16.16 divider: (num * 2^16) / den, truncated toward zero and
// saturated. Restoring, one quotient bit per cycle, then a sign fixup step.
// ----------------------------------------------------------------------------
module pse_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [pse_pkg::Q_W-1:0] num,
  input  logic signed [pse_pkg::Q_W-1:0] den,
  output logic                         done,
  output logic signed [pse_pkg::Q_W-1:0] quo
);

  localparam int QW  = pse_pkg::Q_W;
  localparam int DW  = pse_pkg::DIV_STEPS;
  localparam int CNW = $clog2(pse_pkg::DIV_STEPS + 1);

  logic           busy;
  logic           fix;
  logic [CNW-1:0] cnt;
  logic [QW-1:0]  rem;
  logic [DW-1:0]  dvd;
  logic [QW-1:0]  dvs;
  logic           neg;

  logic [QW-1:0]  num_mag;
  logic [QW-1:0]  den_mag;
  logic [QW:0]    rem_sh;
  logic [QW:0]    diff;
  logic           ge;
  logic [QW-1:0]  sat_q;

  // Operand magnitudes and one restoring step
  always_comb begin
    num_mag = num[QW-1] ? (~num + QW'(1)) : num;
    den_mag = den[QW-1] ? (~den + QW'(1)) : den;
    rem_sh  = {rem, dvd[DW-1]};
    diff    = rem_sh - {1'b0, dvs};
    ge      = (rem_sh >= {1'b0, dvs});
  end

  // Sign fixup and saturation of the quotient magnitude
  always_comb begin
    if (neg) begin
      if (dvd > {{(DW-QW){1'b0}}, 1'b1, {(QW-1){1'b0}}}) begin
        sat_q = {1'b1, {(QW-1){1'b0}}};
      end else begin
        sat_q = ~dvd[QW-1:0] + QW'(1);
      end
    end else begin
      if (dvd > {{(DW-QW+1){1'b0}}, {(QW-1){1'b1}}}) begin
        sat_q = {1'b0, {(QW-1){1'b1}}};
      end else begin
        sat_q = dvd[QW-1:0];
      end
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == CNW'(DW - 1))) begin
        busy <= 1'b0;
        fix  <= 1'b1;
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Shift and subtract registers
  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      dvd <= {num_mag, {(DW-QW){1'b0}}};
      dvs <= den_mag;
      neg <= num[QW-1] ^ den[QW-1];
    end else if (busy) begin
      cnt <= cnt + CNW'(1);
      rem <= ge ? diff[QW-1:0] : rem_sh[QW-1:0];
      dvd <= {dvd[DW-2:0], ge};
    end
    if (fix) begin
      quo <= sat_q;
    end
  end

endmodule

/* rtl/pse_ctrl.sv */
// ----------------------------------------------------------------------------
// pse_ctrl
// Token sequencer: accepts a token, steps the datapath through the operation
// and hands the result word to the output register.
// ----------------------------------------------------------------------------
module pse_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            tok_valid,
  output logic            tok_ready,
  output logic            res_valid,
  input  logic            res_ready,
  input  pse_pkg::sts_t   sts,
  output pse_pkg::cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ADDSUB,
    S_MULP,
    S_MULW,
    S_DIVS,
    S_DIVW,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;
  logic   res_free;

  assign tok_ready = (state == S_IDLE) && !rst;
  assign res_free  = !res_valid || res_ready;

  // Command decode
  always_comb begin
    cmd           = '0;
    cmd.load      = tok_valid && (state == S_IDLE);
    cmd.exec      = (state == S_EXEC);
    cmd.addsub_wr = (state == S_ADDSUB);
    cmd.mul_prod  = (state == S_MULP);
    cmd.mul_wr    = (state == S_MULW);
    cmd.div_start = (state == S_DIVS);
    cmd.div_wr    = (state == S_DIVW) && sts.div_done;
    cmd.emit      = (state == S_RESP) && res_free;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (tok_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!sts.go_bin)     state_next = S_RESP;
        else if (sts.is_mul) state_next = S_MULP;
        else if (sts.is_div) state_next = S_DIVS;
        else                 state_next = S_ADDSUB;
      end
      S_ADDSUB: state_next = S_RESP;
      S_MULP:   state_next = S_MULW;
      S_MULW:   state_next = S_RESP;
      S_DIVS:   state_next = S_DIVW;
      S_DIVW: begin
        if (sts.div_done) state_next = S_RESP;
      end
      S_RESP: begin
        if (res_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/pse_dpath.sv */
// ----------------------------------------------------------------------------
// pse_dpath
// Evaluator datapath: top-of-stack register, stack memory for the entries
// below it, add/sub, multiplier, divider and the result word register.
// ----------------------------------------------------------------------------
module pse_dpath #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pse_pkg::cmd_t                  cmd,
  output pse_pkg::sts_t                  sts,
  input  logic [2:0]                     tok_kind,
  input  logic signed [pse_pkg::Q_W-1:0] tok_operand,
  output pse_pkg::status_t               res_status,
  output logic signed [pse_pkg::Q_W-1:0] res_top_value,
  output logic                           res_final_res
);

  localparam int QW = pse_pkg::Q_W;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  // Token registers
  pse_pkg::kind_t           kind;
  logic signed [QW-1:0]     operand;

  // Stack state
  logic signed [QW-1:0]     tos;
  logic [CW-1:0]            count;
  pse_pkg::status_t         sticky;
  logic signed [QW-1:0]     mem [STACK_DEPTH];
  logic signed [QW-1:0]     mem_rd;

  // Arithmetic and finish registers
  logic signed [2*QW-1:0]   prod;
  pse_pkg::status_t         fin_status;
  logic signed [QW-1:0]     fin_top;

  logic [CW-1:0]            cnt_m1;
  logic [CW-1:0]            cnt_m2;
  logic [AW-1:0]            wr_idx;
  logic [AW-1:0]            rd_idx;
  logic                     full;
  logic                     empty;
  logic                     two;
  logic                     is_bin;
  logic                     no_err;
  logic                     push_ok;
  logic                     neg_ok;
  logic [QW:0]              tos_ext;
  logic [QW:0]              l_ext;
  logic [QW:0]              sum;
  logic [QW-1:0]            addsub_res;
  logic [QW-1:0]            neg_res;
  logic [QW-1:0]            mul_res;
  logic                     div_done;
  logic signed [QW-1:0]     div_quo;

  // Stack pointers and token decode
  always_comb begin
    cnt_m1  = count - CW'(1);
    cnt_m2  = count - CW'(2);
    wr_idx  = cnt_m1[AW-1:0];
    rd_idx  = cnt_m2[AW-1:0];
    full    = (count == CW'(STACK_DEPTH));
    empty   = (count == '0);
    two     = (count >= CW'(2));
    no_err  = (sticky == pse_pkg::ST_OK);
    is_bin  = (kind == pse_pkg::KIND_ADD) || (kind == pse_pkg::KIND_SUB) ||
              (kind == pse_pkg::KIND_MUL) || (kind == pse_pkg::KIND_DIV);
    push_ok = no_err && (kind == pse_pkg::KIND_PUSH) && !full;
    neg_ok  = no_err && (kind == pse_pkg::KIND_NEG) && !empty;
  end

  // Status to controller
  always_comb begin
    sts.go_bin   = no_err && is_bin && two &&
                   !((kind == pse_pkg::KIND_DIV) && (tos == '0));
    sts.is_mul   = (kind == pse_pkg::KIND_MUL);
    sts.is_div   = (kind == pse_pkg::KIND_DIV);
    sts.div_done = div_done;
  end

  // Add, subtract, negate and multiply scaling
  always_comb begin
    tos_ext    = {tos[QW-1], tos};
    l_ext      = {mem_rd[QW-1], mem_rd};
    sum        = (kind == pse_pkg::KIND_SUB) ? (l_ext - tos_ext) : (l_ext + tos_ext);
    addsub_res = pse_pkg::sat33(sum);
    neg_res    = pse_pkg::sat33((QW+1)'(0) - tos_ext);
    // arithmetic shift by 16 rounds toward negative infinity
    mul_res    = pse_pkg::sat48(prod[2*QW-1:16]);
  end

  pse_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (mem_rd),
    .den   (tos),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Stack depth and sticky error
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      sticky <= pse_pkg::ST_OK;
    end else if (cmd.exec) begin
      if (kind == pse_pkg::KIND_FIN) begin
        count  <= '0;
        sticky <= pse_pkg::ST_OK;
      end else if (no_err) begin
        unique case (kind)
          pse_pkg::KIND_PUSH: begin
            if (full) sticky <= pse_pkg::ST_OVERFLOW;
            else      count  <= count + CW'(1);
          end
          pse_pkg::KIND_NEG: begin
            if (empty) sticky <= pse_pkg::ST_UNDERFLOW;
          end
          pse_pkg::KIND_ADD, pse_pkg::KIND_SUB,
          pse_pkg::KIND_MUL, pse_pkg::KIND_DIV: begin
            if (!two) begin
              sticky <= pse_pkg::ST_UNDERFLOW;
            end else if ((kind == pse_pkg::KIND_DIV) && (tos == '0)) begin
              sticky <= pse_pkg::ST_DIVZERO;
            end
          end
          pse_pkg::KIND_BADOP: sticky <= pse_pkg::ST_BADOP;
          default: ;
        endcase
      end
    end else if (cmd.addsub_wr || cmd.mul_wr || cmd.div_wr) begin
      count <= cnt_m1;
    end
  end

  // Stack memory: spill old top on push, read second entry every cycle
  always_ff @(posedge clk) begin
    if (cmd.exec && push_ok && !empty) begin
      mem[wr_idx] <= tos;
    end
    mem_rd <= mem[rd_idx];
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind    <= pse_pkg::kind_t'(tok_kind);
      operand <= tok_operand;
    end
    if (cmd.exec && push_ok) begin
      tos <= operand;
    end else if (cmd.exec && neg_ok) begin
      tos <= neg_res;
    end else if (cmd.addsub_wr) begin
      tos <= addsub_res;
    end else if (cmd.mul_wr) begin
      tos <= mul_res;
    end else if (cmd.div_wr) begin
      tos <= div_quo;
    end
    if (cmd.mul_prod) begin
      prod <= mem_rd * tos;
    end
    // Finish verdict, taken before the stack is cleared
    if (cmd.exec) begin
      if (!no_err) begin
        fin_status <= sticky;
        fin_top    <= '0;
      end else if (count != CW'(1)) begin
        fin_status <= pse_pkg::ST_INVALID;
        fin_top    <= '0;
      end else begin
        fin_status <= pse_pkg::ST_OK;
        fin_top    <= tos;
      end
    end
    // Result word
    if (cmd.emit) begin
      res_final_res <= (kind == pse_pkg::KIND_FIN);
      if (kind == pse_pkg::KIND_FIN) begin
        res_status    <= fin_status;
        res_top_value <= fin_top;
      end else begin
        res_status    <= sticky;
        res_top_value <= empty ? '0 : tos;
      end
    end
  end

endmodule

/* rtl/postfix_stack_evaluator_core.sv */
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_core
// Reverse Polish evaluator on signed Q16.16 values with a sticky error code.
// ----------------------------------------------------------------------------
// One token word in gives one result word out. Tokens are processed one at
// a time: push, negate, finish, bad operator and error cases go straight
// from execute to the result state, add and subtract through a write-back
// state, multiply through one registered 32x32 product, then shift and
// saturate, and divide through the restoring divider that produces one of 48
// quotient bits per cycle. The next token is accepted the cycle after the
// result is loaded into the output register, even if that word has not yet
// been taken. The top of the stack lives in a register; the entries below it
// sit in a STACK_DEPTH-entry memory that needs no clearing after reset.
module postfix_stack_evaluator_core #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  pse_tok_if.sink   tok,
  pse_res_if.source res
);

  pse_pkg::cmd_t    cmd;
  pse_pkg::sts_t    sts;
  pse_pkg::status_t res_status;

  pse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok.valid),
    .tok_ready (tok.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pse_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .tok_kind      (tok.kind),
    .tok_operand   (tok.operand),
    .res_status    (res_status),
    .res_top_value (res.top_value),
    .res_final_res (res.final_res)
  );

  assign res.status = res_status;

  // Checks
  `include "postfix_stack_evaluator_core_assert.svh"

  `PSE_ASSERT_NEXT(a_accept_exec, tok.valid && tok.ready, cmd.exec, "token not executed")
  `PSE_ASSERT_NEXT(a_emit_valid, cmd.emit, res.valid, "result word loaded but not presented")
  `PSE_ASSERT_NOW(a_div_wr_kind, cmd.div_wr, sts.is_div, "divider write-back on a non-divide")

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the postfix stack evaluator core. A queue of tokens
// is built up front: a directed set aimed at saturation, each error code but
// overflow, the finish rules, then random expressions, mostly well formed with a
// minority of broken ones. A clocked driver feeds the token channel. Every
// accepted word goes through a local evaluator model that predicts its
// result. A clocked monitor checks each result word, field by field, against
// the oldest prediction. Both channels idle in short random bursts, and the
// result side holds off once for a long stretch to back up the token input.
// ----------------------------------------------------------------------------
module tb;

  localparam int          STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF;
  localparam int          RAND_WORDS  = 1925;
  localparam int          TAIL_WORDS  = 150;
  localparam int          DRAIN_CYC   = 80;
  localparam int          STALL_AT    = 1500;
  localparam int          STALL_LEN   = 400;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int          MAX_REPORTS = 10;

  localparam logic signed [31:0] Q_MAX_V = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN_V = 32'sh8000_0000;
  localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
  localparam longint             SAT_HI  = 64'sd2147483647;
  localparam longint             SAT_LO  = -64'sd2147483648;

  typedef struct packed {
    pse_pkg::kind_t     kind;
    logic signed [31:0] operand;
  } token_t;

  typedef struct packed {
    pse_pkg::status_t   status;
    logic signed [31:0] top;
    logic               fin;
  } res_word_t;

  logic clk;
  logic rst;

  pse_tok_if tok ();
  pse_res_if res ();

  postfix_stack_evaluator_core dut (
    .clk (clk),
    .rst (rst),
    .tok (tok),
    .res (res)
  );

  token_t      tok_plan_q [$];
  res_word_t   res_due_q  [$];
  int unsigned fail_cnt;
  int unsigned cyc;
  int unsigned stall_left;
  int unsigned stall_clock;
  int unsigned tx_gap;
  int unsigned rx_gap;
  int unsigned words_drawn;
  bit          idle_phase;

  // Evaluator state mirrored by the checker
  logic signed [31:0] stk_m [STACK_DEPTH];
  int unsigned        depth_m;
  pse_pkg::status_t   err_m;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Clamp to the Q16.16 range
  function automatic logic signed [31:0] sat_q(longint v);
    if (v > SAT_HI) return Q_MAX_V;
    if (v < SAT_LO) return Q_MIN_V;
    return v[31:0];
  endfunction

  // Advance the evaluator by one token, return the result word it gives
  function automatic res_word_t eval_token(pse_pkg::kind_t k, logic signed [31:0] opnd);
    res_word_t          r;
    logic signed [31:0] lhs;
    logic signed [31:0] rhs;
    longint             wide;
    r.fin = (k == pse_pkg::KIND_FIN);
    r.top = '0;
    if (k == pse_pkg::KIND_FIN) begin
      if (err_m != pse_pkg::ST_OK) begin
        r.status = err_m;
      end else if (depth_m != 1) begin
        r.status = pse_pkg::ST_INVALID;
      end else begin
        r.status = pse_pkg::ST_OK;
        r.top    = stk_m[0];
      end
      depth_m = 0;
      err_m   = pse_pkg::ST_OK;
      return r;
    end
    // errors are sticky: later tokens leave the stack alone
    if (err_m == pse_pkg::ST_OK) begin
      case (k)
        pse_pkg::KIND_PUSH: begin
          if (depth_m >= STACK_DEPTH) begin
            err_m = pse_pkg::ST_OVERFLOW;
          end else begin
            stk_m[depth_m] = opnd;
            depth_m++;
          end
        end
        pse_pkg::KIND_NEG: begin
          if (depth_m < 1) err_m = pse_pkg::ST_UNDERFLOW;
          else stk_m[depth_m-1] = sat_q(-longint'(stk_m[depth_m-1]));
        end
        pse_pkg::KIND_ADD, pse_pkg::KIND_SUB, pse_pkg::KIND_MUL, pse_pkg::KIND_DIV: begin
          if (depth_m < 2) begin
            err_m = pse_pkg::ST_UNDERFLOW;
          end else begin
            rhs = stk_m[depth_m-1];
            lhs = stk_m[depth_m-2];
            if (k == pse_pkg::KIND_DIV && rhs == 0) begin
              err_m = pse_pkg::ST_DIVZERO;
            end else begin
              case (k)
                pse_pkg::KIND_ADD: wide = longint'(lhs) + longint'(rhs);
                pse_pkg::KIND_SUB: wide = longint'(lhs) - longint'(rhs);
                // floor of the product over 2^16
                pse_pkg::KIND_MUL: wide = (longint'(lhs) * longint'(rhs)) >>> 16;
                // quotient truncates toward zero
                default:  wide = (longint'(lhs) <<< 16) / longint'(rhs);
              endcase
              stk_m[depth_m-2] = sat_q(wide);
              depth_m--;
            end
          end
        end
        default: err_m = pse_pkg::ST_BADOP;
      endcase
    end
    r.status = err_m;
    if (depth_m != 0) r.top = stk_m[depth_m-1];
    return r;
  endfunction

  // Idle bursts only in idle phases and never in the tail of the run
  function automatic bit may_idle();
    return idle_phase && (tok_plan_q.size() > TAIL_WORDS);
  endfunction

  // Q16.16 operand: extremes, small values or any 32-bit pattern
  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 6))
          0: return Q_MAX_V;
          1: return Q_MIN_V;
          2: return 32'sd0;
          3: return 32'sd1;
          4: return -32'sd1;
          5: return Q_ONE;
          default: return -Q_ONE;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_tok(pse_pkg::kind_t k, logic signed [31:0] opnd, bit counts);
    token_t t;
    t.kind    = k;
    t.operand = (k == pse_pkg::KIND_PUSH) ? opnd : $urandom;
    tok_plan_q.push_back(t);
    if (counts) words_drawn++;
  endtask

  function automatic pse_pkg::kind_t rand_binop();
    return pse_pkg::kind_t'($urandom_range(pse_pkg::KIND_ADD, pse_pkg::KIND_DIV));
  endfunction

  // Well-formed expression with random shape, reduced to one value at the end
  task automatic build_expr();
    int unsigned d;
    int unsigned n;
    int unsigned push_pct;
    d        = 0;
    n        = $urandom_range(1, 40);
    push_pct = $urandom_range(35, 85);
    repeat (n) begin
      if (d == 0 || (d < STACK_DEPTH && $urandom_range(0, 99) < push_pct)) begin
        add_tok(pse_pkg::KIND_PUSH, rand_q(), 1'b1);
        d++;
      end else if (d == 1 || $urandom_range(0, 7) == 0) begin
        add_tok(pse_pkg::KIND_NEG, '0, 1'b1);
      end else begin
        add_tok(rand_binop(), '0, 1'b1);
        d--;
      end
    end
    while (d > 1) begin
      add_tok(rand_binop(), '0, 1'b1);
      d--;
    end
    add_tok(pse_pkg::KIND_FIN, '0, 1'b1);
  endtask

  // Expression that trips an error or ends unbalanced
  task automatic build_broken();
    int unsigned n;
    n = 0;
    case ($urandom_range(0, 4))
      0: begin
        // underflow on a short stack
        if ($urandom_range(0, 1) == 1) begin
          add_tok(pse_pkg::KIND_PUSH, rand_q(), 1'b1);
          add_tok(rand_binop(), '0, 1'b1);
        end else begin
          add_tok($urandom_range(0, 1) ? pse_pkg::KIND_NEG : rand_binop(), '0, 1'b1);
        end
      end
      1: begin
        // overflow: one push past a full stack
        repeat (STACK_DEPTH + 1) add_tok(pse_pkg::KIND_PUSH, rand_q(), 1'b1);
      end
      2: begin
        repeat ($urandom_range(0, 3)) add_tok(pse_pkg::KIND_PUSH, rand_q(), 1'b1);
        add_tok(pse_pkg::KIND_BADOP, '0, 1'b1);
      end
      3: begin
        // divide by zero
        add_tok(pse_pkg::KIND_PUSH, rand_q(), 1'b1);
        add_tok(pse_pkg::KIND_PUSH, 32'sd0, 1'b1);
        add_tok(pse_pkg::KIND_DIV, '0, 1'b1);
      end
      default: begin
        // no error, but finish sees zero or several entries
        n = $urandom_range(0, 1) ? 0 : $urandom_range(2, STACK_DEPTH);
        repeat (n) add_tok(pse_pkg::KIND_PUSH, rand_q(), 1'b1);
      end
    endcase
    // tokens after an error are dropped by the block; these follow an error or an empty stack
    if (n == 0) begin
      repeat ($urandom_range(0, 3)) begin
        add_tok(pse_pkg::kind_t'($urandom_range(pse_pkg::KIND_PUSH, pse_pkg::KIND_NEG)),
                rand_q(), 1'b0);
      end
    end
    add_tok(pse_pkg::KIND_FIN, '0, 1'b1);
  endtask

  // Cycle count and idle phase selection
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 97 == 0) idle_phase <= ($urandom_range(0, 3) != 0);
  end

  // Long hold-off on the result side, timed in its own process
  always @(posedge clk) begin
    if (rst) begin
      stall_clock <= 0;
      stall_left  <= 0;
    end else begin
      stall_clock <= stall_clock + 1;
      if (stall_clock == STALL_AT) stall_left <= STALL_LEN;
      else if (stall_left != 0) stall_left <= stall_left - 1;
    end
  end

  // Token driver: predicts each word as it is accepted
  always @(posedge clk) begin
    if (rst) begin
      tok.valid   <= 1'b0;
      tok.kind    <= pse_pkg::KIND_PUSH;
      tok.operand <= '0;
      tx_gap       = 0;
    end else begin
      if (tok.valid && tok.ready) begin
        res_due_q.push_back(eval_token(pse_pkg::kind_t'(tok.kind), tok.operand));
        void'(tok_plan_q.pop_front());
      end
      if (tok.valid && !tok.ready) begin
        // hold the offered word
      end else if (tx_gap != 0) begin
        tok.valid <= 1'b0;
        tx_gap--;
      end else if (tok_plan_q.size() == 0) begin
        tok.valid <= 1'b0;
      end else if (may_idle() && $urandom_range(0, 7) == 0) begin
        tok.valid <= 1'b0;
        tx_gap     = $urandom_range(0, 2);
      end else begin
        tok.valid   <= 1'b1;
        tok.kind    <= tok_plan_q[0].kind;
        tok.operand <= tok_plan_q[0].operand;
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin
    res_word_t want;
    if (rst) begin
      res.ready <= 1'b0;
      rx_gap     = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (res_due_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS) begin
            $display("[%0t] unexpected result word: status %0d top %h final %b",
                     $realtime, res.status, res.top_value, res.final_res);
          end
        end else begin
          want = res_due_q.pop_front();
          if (res.status !== want.status || res.top_value !== want.top ||
              res.final_res !== want.fin) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS) begin
              $display("[%0t] result mismatch: exp status %0d top %h final %b,",
                       $realtime, want.status, want.top, want.fin);
              $display("      got status %0d top %h final %b",
                       res.status, res.top_value, res.final_res);
            end
          end
        end
      end
      if (stall_left != 0) begin
        res.ready <= 1'b0;
      end else if (rx_gap != 0) begin
        res.ready <= 1'b0;
        rx_gap--;
      end else if (may_idle() && $urandom_range(0, 7) == 0) begin
        res.ready <= 1'b0;
        rx_gap     = $urandom_range(0, 2);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  // Run timeout
  initial begin
    while (cyc < CYCLE_LIMIT) @(posedge clk);
    $display("** postfix_stack_evaluator_core: FAILED **");
    $finish;
  end

  // Stimulus plan, reset and end of run
  initial begin
    rst         = 1'b1;
    tok.valid   = 1'b0;
    tok.kind    = pse_pkg::KIND_PUSH;
    tok.operand = '0;
    res.ready   = 1'b0;
    cyc         = 0;
    fail_cnt    = 0;
    words_drawn = 0;
    idle_phase  = 1'b0;
    depth_m     = 0;
    err_m       = pse_pkg::ST_OK;
    foreach (stk_m[i]) stk_m[i] = '0;

    // finish with nothing pushed
    add_tok(pse_pkg::KIND_FIN, '0, 1'b1);
    // add saturates high
    add_tok(pse_pkg::KIND_PUSH, Q_MAX_V, 1'b1);
    add_tok(pse_pkg::KIND_PUSH, Q_MAX_V, 1'b1);
    add_tok(pse_pkg::KIND_ADD, '0, 1'b1);
    add_tok(pse_pkg::KIND_FIN, '0, 1'b1);
    // negate of the most negative value
    add_tok(pse_pkg::KIND_PUSH, Q_MIN_V, 1'b1);
    add_tok(pse_pkg::KIND_NEG, '0, 1'b1);
    add_tok(pse_pkg::KIND_FIN, '0, 1'b1);
    // sub saturates low, then mul saturates high
    add_tok(pse_pkg::KIND_PUSH, Q_MIN_V, 1'b1);
    add_tok(pse_pkg::KIND_PUSH, 32'sd1, 1'b1);
    add_tok(pse_pkg::KIND_SUB, '0, 1'b1);
    add_tok(pse_pkg::KIND_PUSH, Q_MIN_V, 1'b1);
    add_tok(pse_pkg::KIND_MUL, '0, 1'b1);
    add_tok(pse_pkg::KIND_FIN, '0, 1'b1);
    // div saturates high
    add_tok(pse_pkg::KIND_PUSH, Q_MIN_V, 1'b1);
    add_tok(pse_pkg::KIND_PUSH, -32'sd1, 1'b1);
    add_tok(pse_pkg::KIND_DIV, '0, 1'b1);
    add_tok(pse_pkg::KIND_FIN, '0, 1'b1);
    // divide by zero, then a push that must be ignored
    add_tok(pse_pkg::KIND_PUSH, 32'sd5, 1'b1);
    add_tok(pse_pkg::KIND_PUSH, 32'sd0, 1'b1);
    add_tok(pse_pkg::KIND_DIV, '0, 1'b1);
    add_tok(pse_pkg::KIND_PUSH, Q_ONE, 1'b1);
    add_tok(pse_pkg::KIND_FIN, '0, 1'b1);
    // underflow on an empty stack
    add_tok(pse_pkg::KIND_ADD, '0, 1'b1);
    add_tok(pse_pkg::KIND_FIN, '0, 1'b1);
    // unknown operator
    add_tok(pse_pkg::KIND_BADOP, '0, 1'b1);
    add_tok(pse_pkg::KIND_FIN, '0, 1'b1);

    words_drawn = 0;
    while (words_drawn < RAND_WORDS) begin
      if ($urandom_range(0, 99) < 80) build_expr();
      else build_broken();
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (tok_plan_q.size() != 0 || tok.valid || res_due_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYC) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("** postfix_stack_evaluator_core: PASSED **");
    end else begin
      $display("** postfix_stack_evaluator_core: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/pse_pkg.sv
rtl/pse_tok_if.sv
rtl/pse_res_if.sv
rtl/pse_div.sv
rtl/pse_ctrl.sv
rtl/pse_dpath.sv
rtl/postfix_stack_evaluator_core.sv
dv/tb.sv
